// ----- sv/hsv_pkg.sv -----
`timescale 1ns / 1ps

package hsv_pkg;

   localparam int HUE_W = 9;
   localparam int PCT_W = 7;
   localparam int CHAN_W = 8;
   localparam int FRAC_W = 6;
   localparam int SV_W = 2 * PCT_W;
   localparam int NUM_W = 20;
   localparam int Y_W = 24;
   localparam int RECIP_W = 17;
   localparam int PROD_W = Y_W + RECIP_W;
   localparam int RECIP_SHIFT = 32;

   localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
   localparam logic [FRAC_W-1:0] SECTOR_SPAN = 6'd60;
   localparam logic [NUM_W-1:0] V_SCALE = 20'd6000;
   localparam logic [NUM_W-1:0] NUM_FULL = 20'd600000;

   // The channel is floor(n * 255 / 600000), which equals floor(n * 17 / 40000).
   localparam logic [Y_W-1:0] DIVISOR = 24'd40000;
   localparam logic [RECIP_W-1:0] RECIP = 17'd107374;

   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW = 3'd0,
      SECTOR_YELLOW_GREEN = 3'd1,
      SECTOR_GREEN_CYAN = 3'd2,
      SECTOR_CYAN_BLUE = 3'd3,
      SECTOR_BLUE_MAGENTA = 3'd4,
      SECTOR_MAGENTA_RED = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_W-1:0] saturation;
      logic [PCT_W-1:0] brightness;
   } hsv_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic range_error;
   } hsv_rsp_type;

endpackage

// ----- sv/hsv_if.sv -----
`timescale 1ns / 1ps

interface hsv_req_if import hsv_pkg::*; ();
   logic valid;
   logic ready;
   hsv_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hsv_rsp_if import hsv_pkg::*; ();
   logic valid;
   logic ready;
   hsv_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/hsv_to_rgb_converter.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// req_if    in         hue, saturation, brightness
// rsp_if    out        red, green, blue, range_error
//
// One transaction per cycle is accepted and delivered while the response is not stalled.
// The stages are: range check and S*V, chroma and second component, channel
// sum, reciprocal multiply by 1/40000, remainder correction into the output register.
// Reset is synchronous and clears only the stage valid bits.
// Each stage holds while its successor is full and stalled, so bubbles close up
// and a stalled response never blocks acceptance while an earlier stage is empty.

module hsv_to_rgb_converter import hsv_pkg::*; (
   input logic clock,
   input logic reset,
   hsv_req_if.sink req_if,
   hsv_rsp_if.source rsp_if
);

   logic [4:0] valid_ff;
   logic [4:0] stage_en;

   // Stage 1 registers.
   logic s1_err_ff;
   logic [SV_W-1:0] s1_sv_ff;
   logic [PCT_W-1:0] s1_v_ff;
   logic [FRAC_W-1:0] s1_t_ff;
   sector_type s1_sector_ff;

   // Stage 2 registers.
   logic s2_err_ff;
   logic [NUM_W-1:0] s2_cn_ff;
   logic [NUM_W-1:0] s2_xn_ff;
   logic [NUM_W-1:0] s2_mn_ff;
   sector_type s2_sector_ff;

   // Stage 3 and 4 registers, one entry per channel (red, green, blue).
   logic s3_err_ff;
   logic [Y_W-1:0] s3_y_ff [3];
   logic s4_err_ff;
   logic [Y_W-1:0] s4_y_ff [3];
   logic [CHAN_W-1:0] s4_q_ff [3];

   hsv_rsp_type rsp_data_ff;

   logic s1_err_in;
   logic [SV_W-1:0] s1_sv_in;
   logic [PCT_W-1:0] s1_v_in;
   logic [FRAC_W-1:0] s1_t_in;
   sector_type s1_sector_in;
   logic [HUE_W-1:0] hue_base;
   logic [HUE_W-1:0] hue_off;
   logic [FRAC_W-1:0] hue_rem;

   logic [NUM_W-1:0] s2_cn_in;
   logic [NUM_W-1:0] s2_xn_in;
   logic [NUM_W-1:0] s2_mn_in;

   logic [NUM_W-1:0] comp [3];
   logic [NUM_W-1:0] chan_num [3];
   logic [Y_W-1:0] s3_y_in [3];

   logic [PROD_W-1:0] recip_prod [3];
   logic [Y_W-1:0] chan_rem [3];
   logic [CHAN_W-1:0] chan_out [3];

   always_comb begin
      stage_en[4] = !valid_ff[4] || rsp_if.ready;
      for (int k = 3; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_if.ready = stage_en[0];
   assign rsp_if.valid = valid_ff[4];
   assign rsp_if.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 4; k >= 1; k--) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (stage_en[0]) begin
            valid_ff[0] <= req_if.valid;
         end
      end
   end

   // Stage 1: range check, sector search and S*V. An out-of-range transaction
   // runs with S and V forced to zero, which yields black.
   always_comb begin
      s1_err_in = (req_if.payload.hue > HUE_MAX) || (req_if.payload.saturation > PCT_MAX)
                  || (req_if.payload.brightness > PCT_MAX);
      if (req_if.payload.hue >= 9'd300) begin
         s1_sector_in = SECTOR_MAGENTA_RED;
         hue_base = 9'd300;
      end else if (req_if.payload.hue >= 9'd240) begin
         s1_sector_in = SECTOR_BLUE_MAGENTA;
         hue_base = 9'd240;
      end else if (req_if.payload.hue >= 9'd180) begin
         s1_sector_in = SECTOR_CYAN_BLUE;
         hue_base = 9'd180;
      end else if (req_if.payload.hue >= 9'd120) begin
         s1_sector_in = SECTOR_GREEN_CYAN;
         hue_base = 9'd120;
      end else if (req_if.payload.hue >= 9'd60) begin
         s1_sector_in = SECTOR_YELLOW_GREEN;
         hue_base = 9'd60;
      end else begin
         s1_sector_in = SECTOR_RED_YELLOW;
         hue_base = 9'd0;
      end
      hue_off = req_if.payload.hue - hue_base;
      hue_rem = hue_off[FRAC_W-1:0];
      // Odd sectors fall as the hue rises; a hue of 360 lands at the end of the last one.
      s1_t_in = s1_sector_in[0] ? (SECTOR_SPAN - hue_rem) : hue_rem;
      if (s1_err_in) begin
         s1_sv_in = '0;
         s1_v_in = '0;
      end else begin
         s1_sv_in = SV_W'(req_if.payload.saturation) * SV_W'(req_if.payload.brightness);
         s1_v_in = req_if.payload.brightness;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_err_ff <= s1_err_in;
         s1_sv_ff <= s1_sv_in;
         s1_v_ff <= s1_v_in;
         s1_t_ff <= s1_t_in;
         s1_sector_ff <= s1_sector_in;
      end
   end

   // Stage 2: numerators over the common denominator 600000.
   always_comb begin
      s2_cn_in = NUM_W'(s1_sv_ff) * NUM_W'(SECTOR_SPAN);
      s2_xn_in = NUM_W'(s1_sv_ff) * NUM_W'(s1_t_ff);
      s2_mn_in = NUM_W'(s1_v_ff) * V_SCALE - s2_cn_in;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_err_ff <= s1_err_ff;
         s2_cn_ff <= s2_cn_in;
         s2_xn_ff <= s2_xn_in;
         s2_mn_ff <= s2_mn_in;
         s2_sector_ff <= s1_sector_ff;
      end
   end

   // Stage 3: component order by sector, add the offset, scale by 17.
   always_comb begin
      case (s2_sector_ff)
         SECTOR_RED_YELLOW: begin
            comp[0] = s2_cn_ff; comp[1] = s2_xn_ff; comp[2] = '0;
         end
         SECTOR_YELLOW_GREEN: begin
            comp[0] = s2_xn_ff; comp[1] = s2_cn_ff; comp[2] = '0;
         end
         SECTOR_GREEN_CYAN: begin
            comp[0] = '0; comp[1] = s2_cn_ff; comp[2] = s2_xn_ff;
         end
         SECTOR_CYAN_BLUE: begin
            comp[0] = '0; comp[1] = s2_xn_ff; comp[2] = s2_cn_ff;
         end
         SECTOR_BLUE_MAGENTA: begin
            comp[0] = s2_xn_ff; comp[1] = '0; comp[2] = s2_cn_ff;
         end
         default: begin
            comp[0] = s2_cn_ff; comp[1] = '0; comp[2] = s2_xn_ff;
         end
      endcase
      for (int c = 0; c < 3; c++) begin
         chan_num[c] = comp[c] + s2_mn_ff;
         s3_y_in[c] = (Y_W'(chan_num[c]) << 4) + Y_W'(chan_num[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_err_ff <= s2_err_ff;
         for (int c = 0; c < 3; c++) begin
            s3_y_ff[c] <= s3_y_in[c];
         end
      end
   end

   // Stage 4: quotient estimate by the reciprocal of 40000, low by at most one.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         recip_prod[c] = PROD_W'(s3_y_ff[c]) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_err_ff <= s3_err_ff;
         for (int c = 0; c < 3; c++) begin
            s4_y_ff[c] <= s3_y_ff[c];
            s4_q_ff[c] <= recip_prod[c][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
         end
      end
   end

   // Stage 5: remainder check fixes the estimate.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         chan_rem[c] = s4_y_ff[c] - Y_W'(s4_q_ff[c]) * DIVISOR;
         chan_out[c] = (chan_rem[c] >= DIVISOR) ? (s4_q_ff[c] + 8'd1) : s4_q_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         rsp_data_ff.red <= chan_out[0];
         rsp_data_ff.green <= chan_out[1];
         rsp_data_ff.blue <= chan_out[2];
         rsp_data_ff.range_error <= s4_err_ff;
      end
   end

   a_error_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.payload.range_error) |->
      (rsp_if.payload.red == '0 && rsp_if.payload.green == '0 && rsp_if.payload.blue == '0))
      else $error("Range error response carries a nonzero color.");

   a_estimate_close: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (chan_rem[0] < (DIVISOR << 1) && chan_rem[1] < (DIVISOR << 1)
                       && chan_rem[2] < (DIVISOR << 1)))
      else $error("Reciprocal estimate is off by more than one.");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] |-> (s2_cn_ff <= NUM_FULL && s2_xn_ff <= s2_cn_ff
                       && (s2_cn_ff + s2_mn_ff) <= NUM_FULL))
      else $error("Channel numerator exceeds full scale.");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> valid_ff[0])
      else $error("Accepted transaction did not enter the first stage.");

endmodule
